// ===== sv/f2dc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package f2dc_pkg;

    // Fixed widths of the register fields and of the result.
    localparam int ROW_WIDTH_BITS = 11;
    localparam int KSIZE_BITS     = 3;
    localparam int COEFF_IDX_BITS = 3;
    localparam int RESULT_BITS    = 40;
    localparam int CFG_INDEX_BITS = 2;

    // Frame tag kept beside each line buffer word.
    localparam int EPOCH_BITS = 8;

    // Result queue depth; a power of two so the pointers wrap by themselves.
    localparam int OUT_DEPTH = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_WIDTH   = 2'd0,
        CFG_KERNEL_ROWS = 2'd1,
        CFG_KERNEL_COLS = 2'd2
    } cfg_index_t;

    localparam logic OP_COEFF  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic {
        ST_SWEEP = 1'b0,
        ST_RUN   = 1'b1
    } sweep_state_t;

    typedef struct packed {
        logic prod_valid;
        logic rows_valid;
    } mac_status_t;

endpackage

`default_nettype wire

// ===== sv/f2dc_line_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module f2dc_line_buffer #(
    parameter int DEPTH  = 1028,
    parameter int WORD_W = 88
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]        wr_word,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WORD_W-1:0]        rd_word
);
    import f2dc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        // A write to the column being fetched is forwarded so the read sees it.
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_word_reg <= wr_word;
        end
        else
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

// ===== sv/f2dc_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module f2dc_mac #(
    parameter int KERNEL_MAX  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_eor,
    input  wire logic signed [SAMPLE_BITS-1:0]         window [KERNEL_MAX][KERNEL_MAX],
    input  wire logic signed [SAMPLE_BITS-1:0]         kernel [KERNEL_MAX][KERNEL_MAX],
    input  wire logic        [$clog2(KERNEL_MAX+1)-1:0] kr,
    input  wire logic        [$clog2(KERNEL_MAX+1)-1:0] kc,
    output f2dc_pkg::mac_status_t                      status,
    output logic                                       out_valid,
    output logic                                       out_eor,
    output logic signed [f2dc_pkg::RESULT_BITS-1:0]    out_sum
);
    import f2dc_pkg::*;

    localparam int KCNT_W = $clog2(KERNEL_MAX + 1);

    logic signed [RESULT_BITS-1:0] prod_next [KERNEL_MAX][KERNEL_MAX];
    logic signed [RESULT_BITS-1:0] prod_reg  [KERNEL_MAX][KERNEL_MAX];
    logic signed [RESULT_BITS-1:0] row_next  [KERNEL_MAX];
    logic signed [RESULT_BITS-1:0] row_reg   [KERNEL_MAX];
    logic                          prod_valid_reg;
    logic                          prod_eor_reg;
    logic                          rows_valid_reg;
    logic                          rows_eor_reg;

    for (genvar a = 0; a < KERNEL_MAX; a++)
    begin : g_row
        for (genvar b = 0; b < KERNEL_MAX; b++)
        begin : g_tap
            logic signed [2*SAMPLE_BITS-1:0] mult;
            logic                            use_tap;

            assign mult    = kernel[a][b] * window[a][b];
            assign use_tap = (KCNT_W'(a) < kr) && (KCNT_W'(b) < kc);
            assign prod_next[a][b] = use_tap ? RESULT_BITS'(mult) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_eor_reg <= in_eor;
        row_reg      <= row_next;
        rows_eor_reg <= prod_eor_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            rows_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            rows_valid_reg <= prod_valid_reg;
        end
    end

    // Each kernel row is summed first, then the row sums.
    always_comb
    begin
        for (int a = 0; a < KERNEL_MAX; a++)
        begin
            row_next[a] = '0;
            for (int b = 0; b < KERNEL_MAX; b++)
            begin
                row_next[a] = row_next[a] + prod_reg[a][b];
            end
        end
    end

    always_comb
    begin
        out_sum = '0;
        for (int a = 0; a < KERNEL_MAX; a++)
        begin
            out_sum = out_sum + row_reg[a];
        end
    end

    assign out_valid         = rows_valid_reg;
    assign out_eor           = rows_eor_reg;
    assign status.prod_valid = prod_valid_reg;
    assign status.rows_valid = rows_valid_reg;

endmodule

`default_nettype wire

// ===== sv/full_2d_convolution_core.sv =====
// Streaming full 2-D convolution with a kernel of up to KERNEL_MAX x KERNEL_MAX.
// Input stream (s_*): tuser[0] selects the kind of transaction, 0 loads one kernel
// coefficient at (coeff_row, coeff_col), 1 delivers one raster sample; tuser[1]
// marks the first sample of a frame. The host pads each row with kernel_cols-1
// zeros and the frame with kernel_rows-1 zero rows.
// Output stream (m_*): one 40-bit exact sum per sample, tlast closes a padded row.
// Coefficient loads give no output transaction.
// Registers are written through cfg_wen/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it. Throughput
// is one transaction per cycle while s_tready is high. An accepted sample passes one
// stage that fetches the line buffer column and shifts the window, one that forms
// the products and one that adds each kernel row; the total is queued in an
// eight-entry result FIFO. When the receiver stalls the FIFO fills, and s_tready
// drops once the FIFO entries plus the samples in flight reach its depth; nothing
// is lost. After reset the line buffer memory is cleared one column per cycle with
// s_tready low. Each frame start bumps a frame tag stored with every column; when
// the tag runs out, the frame start that finds it at its maximum waits for the same
// clearing pass before it is taken.
`timescale 1ns / 1ps
`default_nettype none

module full_2d_convolution_core #(
    parameter int KERNEL_MAX  = 5,
    parameter int ROW_MAX     = 1028,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wen,
    input  wire logic [f2dc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [f2dc_pkg::ROW_WIDTH_BITS-1:0]    cfg_data,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // coeff_row, coeff_col, value, zero fill
    input  wire logic [((2*f2dc_pkg::COEFF_IDX_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // op, frame_start
    input  wire logic [1:0]                             s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // result
    output logic [f2dc_pkg::RESULT_BITS-1:0]            m_tdata,
    output logic                                        m_tlast
);
    import f2dc_pkg::*;

    localparam int COL_W     = $clog2(ROW_MAX);
    localparam int CMP_W     = (COL_W + 1 > ROW_WIDTH_BITS) ? COL_W + 1 : ROW_WIDTH_BITS;
    localparam int KCNT_W    = $clog2(KERNEL_MAX + 1);
    localparam int SAMPLES_W = KERNEL_MAX * SAMPLE_BITS;
    localparam int WORD_W    = SAMPLES_W + EPOCH_BITS;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 4);
    localparam int VAL_LSB   = 2 * COEFF_IDX_BITS;

    // Input fields.
    logic                          in_op;
    logic                          in_fs;
    logic [COEFF_IDX_BITS-1:0]     in_row;
    logic [COEFF_IDX_BITS-1:0]     in_col;
    logic signed [SAMPLE_BITS-1:0] in_value;

    assign in_op    = s_tuser[0];
    assign in_fs    = s_tuser[1];
    assign in_row   = s_tdata[COEFF_IDX_BITS-1:0];
    assign in_col   = s_tdata[2*COEFF_IDX_BITS-1:COEFF_IDX_BITS];
    assign in_value = s_tdata[VAL_LSB +: SAMPLE_BITS];

    // Configuration.
    logic [ROW_WIDTH_BITS-1:0] row_width_reg;
    logic [KSIZE_BITS-1:0]     kernel_rows_reg;
    logic [KSIZE_BITS-1:0]     kernel_cols_reg;
    logic [CMP_W-1:0]          rw_eff;
    logic [KCNT_W-1:0]         kr_eff;
    logic [KCNT_W-1:0]         kc_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= ROW_WIDTH_BITS'(ROW_MAX);
            kernel_rows_reg <= KSIZE_BITS'(KERNEL_MAX);
            kernel_cols_reg <= KSIZE_BITS'(KERNEL_MAX);
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROW_WIDTH:   row_width_reg   <= cfg_data;
                CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[KSIZE_BITS-1:0];
                CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[KSIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (row_width_reg == '0)
        begin
            rw_eff = CMP_W'(1);
        end
        else if (CMP_W'(row_width_reg) > CMP_W'(ROW_MAX))
        begin
            rw_eff = CMP_W'(ROW_MAX);
        end
        else
        begin
            rw_eff = CMP_W'(row_width_reg);
        end

        if (kernel_rows_reg == '0)
        begin
            kr_eff = KCNT_W'(1);
        end
        else if (int'(kernel_rows_reg) > KERNEL_MAX)
        begin
            kr_eff = KCNT_W'(KERNEL_MAX);
        end
        else
        begin
            kr_eff = KCNT_W'(kernel_rows_reg);
        end

        if (kernel_cols_reg == '0)
        begin
            kc_eff = KCNT_W'(1);
        end
        else if (int'(kernel_cols_reg) > KERNEL_MAX)
        begin
            kc_eff = KCNT_W'(KERNEL_MAX);
        end
        else
        begin
            kc_eff = KCNT_W'(kernel_cols_reg);
        end
    end

    // Clearing sequencer for the line buffer memory.
    sweep_state_t         state_reg;
    sweep_state_t         state_next;
    logic [COL_W-1:0]     sweep_addr_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic                 sweep_active;
    logic                 sweep_done;
    logic                 sweep_req;

    assign sweep_done = (sweep_addr_reg == COL_W'(ROW_MAX - 1));
    assign sweep_req  = s_tvalid && (in_op == OP_SAMPLE) && in_fs
                        && (epoch_reg == {EPOCH_BITS{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sweep_req)
                begin
                    state_next = ST_SWEEP;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SWEEP: sweep_active = 1'b1;
            ST_RUN:   sweep_active = 1'b0;
            default:  sweep_active = 1'b1;
        endcase
    end

    // Handshake and position tracking.
    mac_status_t      mac_status;
    logic [CNT_W-1:0] fifo_count_reg;
    logic [OCC_W-1:0] occupancy;
    logic             s1_valid_reg;
    logic             s_acc;
    logic             samp_acc;
    logic             coef_acc;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_use;
    logic [CMP_W-1:0] col_plus1;
    logic             eor;

    assign occupancy = OCC_W'(fifo_count_reg) + OCC_W'(s1_valid_reg)
                     + OCC_W'(mac_status.prod_valid) + OCC_W'(mac_status.rows_valid);

    assign s_tready = !sweep_active && (occupancy < OCC_W'(OUT_DEPTH))
                      && !((in_op == OP_SAMPLE) && in_fs
                           && (epoch_reg == {EPOCH_BITS{1'b1}}));

    assign s_acc    = s_tvalid && s_tready;
    assign samp_acc = s_acc && (in_op == OP_SAMPLE);
    assign coef_acc = s_acc && (in_op == OP_COEFF);

    assign col_use   = in_fs ? '0 : col_reg;
    assign col_plus1 = CMP_W'(col_use) + CMP_W'(1);
    assign eor       = (col_plus1 >= rw_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            epoch_reg      <= '0;
            col_reg        <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweep_active)
            begin
                sweep_addr_reg <= sweep_done ? '0 : sweep_addr_reg + COL_W'(1);
            end
            if ((state_reg == ST_RUN) && (state_next == ST_SWEEP))
            begin
                epoch_reg <= '0;
            end
            else if (samp_acc && in_fs)
            begin
                epoch_reg <= epoch_reg + EPOCH_BITS'(1);
            end
            if (samp_acc)
            begin
                col_reg <= eor ? '0 : col_use + COL_W'(1);
            end
            s1_valid_reg <= samp_acc;
        end
    end

    // Kernel coefficients; a load with an index past the kernel matches nothing.
    logic signed [SAMPLE_BITS-1:0] kernel_reg [KERNEL_MAX][KERNEL_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < KERNEL_MAX; a++)
            begin
                for (int b = 0; b < KERNEL_MAX; b++)
                begin
                    kernel_reg[a][b] <= '0;
                end
            end
        end
        else
        begin
            for (int a = 0; a < KERNEL_MAX; a++)
            begin
                for (int b = 0; b < KERNEL_MAX; b++)
                begin
                    if (coef_acc && (int'(in_row) == a) && (int'(in_col) == b))
                    begin
                        kernel_reg[a][b] <= in_value;
                    end
                end
            end
        end
    end

    // First stage: the sample, its column and frame tag.
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [EPOCH_BITS-1:0]         s1_epoch_reg;
    logic                          s1_eor_reg;

    always_ff @(posedge clk)
    begin
        if (samp_acc)
        begin
            s1_x_reg     <= in_value;
            s1_col_reg   <= col_use;
            s1_epoch_reg <= in_fs ? epoch_reg + EPOCH_BITS'(1) : epoch_reg;
            s1_eor_reg   <= eor;
        end
    end

    // Line buffer: one word per column holds the samples above it, newest lowest.
    logic                  lb_wr_en;
    logic [COL_W-1:0]      lb_wr_addr;
    logic [WORD_W-1:0]     lb_wr_word;
    logic [WORD_W-1:0]     lb_rd_word;
    logic                  hist_ok;
    logic [SAMPLES_W-1:0]  hist_samples;
    logic [SAMPLES_W-1:0]  samples_next;

    // A word written in an earlier frame reads as an empty column.
    assign hist_ok      = (lb_rd_word[WORD_W-1 -: EPOCH_BITS] == s1_epoch_reg);
    assign hist_samples = hist_ok ? lb_rd_word[SAMPLES_W-1:0] : '0;
    assign samples_next = SAMPLES_W'({hist_samples, s1_x_reg});

    assign lb_wr_en   = sweep_active || s1_valid_reg;
    assign lb_wr_addr = sweep_active ? sweep_addr_reg : s1_col_reg;
    assign lb_wr_word = sweep_active ? '0 : {s1_epoch_reg, samples_next};

    f2dc_line_buffer #(
        .DEPTH  (ROW_MAX),
        .WORD_W (WORD_W)
    ) u_line_buffer (
        .clk     (clk),
        .wr_en   (lb_wr_en),
        .wr_addr (lb_wr_addr),
        .wr_word (lb_wr_word),
        .rd_addr (col_reg),
        .rd_word (lb_rd_word)
    );

    // Window shift; the history is dropped at the start of every row.
    logic signed [SAMPLE_BITS-1:0] window_reg  [KERNEL_MAX][KERNEL_MAX];
    logic signed [SAMPLE_BITS-1:0] window_next [KERNEL_MAX][KERNEL_MAX];

    for (genvar a = 0; a < KERNEL_MAX; a++)
    begin : g_win_row
        if (a == 0)
        begin : g_fresh_x
            assign window_next[a][0] = s1_x_reg;
        end
        else
        begin : g_fresh_lb
            assign window_next[a][0] = hist_samples[(a-1)*SAMPLE_BITS +: SAMPLE_BITS];
        end
        for (genvar b = 1; b < KERNEL_MAX; b++)
        begin : g_win_col
            assign window_next[a][b] = (s1_col_reg == '0) ? '0 : window_reg[a][b-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            window_reg <= window_next;
        end
    end

    logic                          mac_valid;
    logic                          mac_eor;
    logic signed [RESULT_BITS-1:0] mac_sum;

    f2dc_mac #(
        .KERNEL_MAX  (KERNEL_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_eor    (s1_eor_reg),
        .window    (window_next),
        .kernel    (kernel_reg),
        .kr        (kr_eff),
        .kc        (kc_eff),
        .status    (mac_status),
        .out_valid (mac_valid),
        .out_eor   (mac_eor),
        .out_sum   (mac_sum)
    );

    // Result FIFO; the occupancy check above keeps a slot for every sample in flight.
    logic [RESULT_BITS:0] fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic                 pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tdata  = fifo_reg[rd_ptr_reg][RESULT_BITS-1:0];
    assign m_tlast  = fifo_reg[rd_ptr_reg][RESULT_BITS];

    always_ff @(posedge clk)
    begin
        if (mac_valid)
        begin
            fifo_reg[wr_ptr_reg] <= {mac_eor, mac_sum};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (mac_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (mac_valid && !pop)
            begin
                fifo_count_reg <= fifo_count_reg + CNT_W'(1);
            end
            else if (pop && !mac_valid)
            begin
                fifo_count_reg <= fifo_count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
